// File: design/obstacle_avoid_phase_fsm_assert.svh
// Assertion macros shared by the obstacle-avoidance phase machine.
`ifndef OBSTACLE_AVOID_PHASE_FSM_ASSERT_SVH
`define OBSTACLE_AVOID_PHASE_FSM_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define OAP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("oap assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define OAP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("oap assertion failed: next-cycle implication");

`endif

// File: design/oap_pkg.sv
// Package with types and constants of the obstacle-avoidance phase machine.
`default_nettype none

package oap_pkg;

   typedef enum logic [2:0] {
      PH_CRUISE  = 3'd1,
      PH_HOLD    = 3'd2,
      PH_AVOID   = 3'd3,
      PH_RECHECK = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      CSR_MODE            = 3'd0,
      CSR_CRUISE_THRESH   = 3'd1,
      CSR_MIN_DISPARITY   = 3'd2,
      CSR_HOLD_WAIT       = 3'd3,
      CSR_CLEAR_THRESH    = 3'd4,
      CSR_RECHECK_THRESH  = 3'd5,
      CSR_RECHECK_WAIT    = 3'd6,
      CSR_CRUISE_CONFIRM  = 3'd7
   } csr_index_type;

   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [7:0] CLEAR_CONFIRM   = 8'd1;
   localparam logic [7:0] RECHECK_CONFIRM = 8'd2;

   typedef struct packed {
      logic        mode;
      logic [15:0] cruise_obstacle_threshold;
      logic [15:0] min_disparity_count;
      logic [15:0] hold_wait_ms;
      logic [15:0] clear_threshold;
      logic [15:0] recheck_threshold;
      logic [15:0] recheck_wait_ms;
      logic [7:0]  cruise_confirm_count;
   } cfg_type;

   typedef struct packed {
      logic [15:0] high_disparities;
      logic [15:0] total_disparities;
      logic [15:0] histogram_obstacle;
      logic [15:0] left_count;
      logic [15:0] right_count;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      phase_type phase_out;
      logic      obstacle_led;
   } rsp_type;

endpackage

`default_nettype wire

// File: design/oap_if.sv
// Handshake interfaces for the frame input channel and the phase result channel.
`default_nettype none

interface oap_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] high_disparities;
   logic [15:0] total_disparities;
   logic [15:0] histogram_obstacle;
   logic [15:0] left_count;
   logic [15:0] right_count;
   logic [31:0] now_ms;

   modport source (
      output valid, high_disparities, total_disparities, histogram_obstacle,
             left_count, right_count, now_ms,
      input  ready
   );
   modport sink (
      input  valid, high_disparities, total_disparities, histogram_obstacle,
             left_count, right_count, now_ms,
      output ready
   );
endinterface

interface oap_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] phase_out;
   logic       obstacle_led;

   modport source (output valid, phase_out, obstacle_led, input ready);
   modport sink (input valid, phase_out, obstacle_led, output ready);
endinterface

`default_nettype wire

// File: design/oap_csr.sv
// Configuration register file of the obstacle-avoidance phase machine.
`default_nettype none

module oap_csr (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           csr_wr_en,
   input  wire  [2:0]                    csr_index,
   input  wire  [oap_pkg::CSR_DATA_W-1:0] csr_wdata,
   output oap_pkg::cfg_type              cfg
);
   import oap_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode                      <= 1'b0;
         cfg_ff.cruise_obstacle_threshold <= 16'd7;
         cfg_ff.min_disparity_count       <= 16'd20;
         cfg_ff.hold_wait_ms              <= 16'd1300;
         cfg_ff.clear_threshold           <= 16'd10;
         cfg_ff.recheck_threshold         <= 16'd10;
         cfg_ff.recheck_wait_ms           <= 16'd500;
         cfg_ff.cruise_confirm_count      <= 8'd3;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_MODE:           cfg_ff.mode                      <= csr_wdata[0];
            CSR_CRUISE_THRESH:  cfg_ff.cruise_obstacle_threshold <= csr_wdata;
            CSR_MIN_DISPARITY:  cfg_ff.min_disparity_count       <= csr_wdata;
            CSR_HOLD_WAIT:      cfg_ff.hold_wait_ms              <= csr_wdata;
            CSR_CLEAR_THRESH:   cfg_ff.clear_threshold           <= csr_wdata;
            CSR_RECHECK_THRESH: cfg_ff.recheck_threshold         <= csr_wdata;
            CSR_RECHECK_WAIT:   cfg_ff.recheck_wait_ms           <= csr_wdata;
            CSR_CRUISE_CONFIRM: cfg_ff.cruise_confirm_count      <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: design/oap_phase.sv
// Phase state, hit counters and next-phase logic for one frame.
`default_nettype none

module oap_phase (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    advance,
   input  wire oap_pkg::cfg_type  cfg,
   input  wire oap_pkg::req_type  frame,
   output oap_pkg::rsp_type       result
);
   import oap_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  cruise_hits_ff, cruise_hits_in;
   logic [7:0]  clear_hits_ff, clear_hits_in;
   logic [7:0]  recheck_hits_ff, recheck_hits_in;
   logic [31:0] entry_time_ff, entry_time_in;

   logic [31:0] elapsed;
   logic        seen;
   logic        clear;
   logic        recheck_hit;
   logic [7:0]  cruise_step;
   logic [7:0]  clear_step;
   logic [7:0]  recheck_step;

   function automatic logic [7:0] sat_inc(input logic [7:0] v);
      sat_inc = (v == 8'hFF) ? v : v + 8'd1;
   endfunction

   always_comb begin
      elapsed = frame.now_ms - entry_time_ff;
      seen = (frame.high_disparities > cfg.cruise_obstacle_threshold) ||
             (frame.total_disparities < cfg.min_disparity_count);

      if (cfg.mode) begin
         clear = (frame.high_disparities < cfg.clear_threshold) &&
                 (frame.left_count > cfg.min_disparity_count) &&
                 (frame.right_count > cfg.min_disparity_count);
      end else begin
         clear = (frame.high_disparities < cfg.clear_threshold) &&
                 (frame.total_disparities > cfg.min_disparity_count);
      end
      recheck_hit = (frame.high_disparities > cfg.recheck_threshold) ||
                    (frame.total_disparities < cfg.min_disparity_count);

      if (seen) begin
         cruise_step = sat_inc(cruise_hits_ff);
      end else if (cruise_hits_ff != 8'd0) begin
         cruise_step = cruise_hits_ff - 8'd1;
      end else begin
         cruise_step = cruise_hits_ff;
      end
      clear_step   = clear ? sat_inc(clear_hits_ff) : 8'd0;
      recheck_step = recheck_hit ? sat_inc(recheck_hits_ff) : 8'd0;

      phase_in        = phase_ff;
      cruise_hits_in  = cruise_hits_ff;
      clear_hits_in   = clear_hits_ff;
      recheck_hits_in = recheck_hits_ff;
      entry_time_in   = entry_time_ff;

      case (phase_ff)
         PH_CRUISE: begin
            if (cfg.mode) begin
               // Low-texture rule skips hold and leaves the counter alone.
               if ((frame.histogram_obstacle > cfg.cruise_obstacle_threshold) ||
                   (frame.left_count < cfg.min_disparity_count) ||
                   (frame.right_count < cfg.min_disparity_count)) begin
                  phase_in      = PH_AVOID;
                  entry_time_in = frame.now_ms;
               end
            end else if (cruise_step > cfg.cruise_confirm_count) begin
               phase_in       = PH_HOLD;
               cruise_hits_in = 8'd0;
               entry_time_in  = frame.now_ms;
            end else begin
               cruise_hits_in = cruise_step;
            end
         end
         PH_HOLD: begin
            if (elapsed > {16'd0, cfg.hold_wait_ms}) begin
               phase_in = PH_AVOID;
            end
         end
         PH_AVOID: begin
            if (clear_step > CLEAR_CONFIRM) begin
               phase_in      = PH_RECHECK;
               clear_hits_in = 8'd0;
               entry_time_in = frame.now_ms;
            end else begin
               clear_hits_in = clear_step;
            end
         end
         PH_RECHECK: begin
            if (recheck_step > RECHECK_CONFIRM) begin
               phase_in        = PH_AVOID;
               recheck_hits_in = 8'd0;
            end else if (elapsed > {16'd0, cfg.recheck_wait_ms}) begin
               phase_in        = PH_CRUISE;
               recheck_hits_in = 8'd0;
            end else begin
               recheck_hits_in = recheck_step;
            end
         end
         default: begin
            phase_in = PH_CRUISE;
         end
      endcase

      result.phase_out    = phase_in;
      result.obstacle_led = seen;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_CRUISE;
         cruise_hits_ff  <= 8'd0;
         clear_hits_ff   <= 8'd0;
         recheck_hits_ff <= 8'd0;
         entry_time_ff   <= 32'd0;
      end else if (advance) begin
         phase_ff        <= phase_in;
         cruise_hits_ff  <= cruise_hits_in;
         clear_hits_ff   <= clear_hits_in;
         recheck_hits_ff <= recheck_hits_in;
         entry_time_ff   <= entry_time_in;
      end
   end

endmodule

`default_nettype wire

// File: design/obstacle_avoid_phase_fsm.sv
// Top level of the obstacle-avoidance phase machine.
// Usage:
//   One transaction on req_chan carries one stereo frame: disparity counts and a
//   millisecond timestamp. Each frame yields exactly one transaction on rsp_chan
//   with the phase after the update (1 cruise, 2 hold, 3 avoid, 4 recheck) and
//   the obstacle LED flag.
//   The csr_ port writes the eight configuration registers, one per cycle, with
//   no read-back; write them only while no frame is in flight.
//   An accepted frame sits in the input register until the result register is
//   free; the phase logic then loads its result into the result register.
//   Throughput is one frame per cycle while the receiver does not stall; the phase
//   state update between the input and result registers is the only loop.
//   A synchronous reset empties both registers, returns the phase to cruise,
//   clears the counters and entry time, and restores register defaults.
//   When the receiver stalls, the result register holds; the input register
//   still takes one more frame, and then req_chan.ready drops until the result
//   is taken.
`default_nettype none

`include "obstacle_avoid_phase_fsm_assert.svh"

module obstacle_avoid_phase_fsm (
   input  wire                            clock,
   input  wire                            reset,
   oap_req_if.sink                        req_chan,
   oap_rsp_if.source                      rsp_chan,
   input  wire                            csr_wr_en,
   input  wire  [2:0]                     csr_index,
   input  wire  [oap_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import oap_pkg::*;

   cfg_type cfg;
   req_type frame_ff;
   logic    frame_valid_ff;
   rsp_type result;
   rsp_type result_ff;
   logic    result_valid_ff;
   logic    advance;
   logic    req_accept;

   assign advance    = frame_valid_ff && (!result_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !frame_valid_ff || advance;
   assign req_accept = req_chan.valid && req_chan.ready;

   oap_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   oap_phase u_phase (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .cfg     (cfg),
      .frame   (frame_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_valid_ff  <= 1'b0;
         result_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            frame_valid_ff <= 1'b1;
         end else if (advance) begin
            frame_valid_ff <= 1'b0;
         end
         if (advance) begin
            result_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            result_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         frame_ff.high_disparities   <= req_chan.high_disparities;
         frame_ff.total_disparities  <= req_chan.total_disparities;
         frame_ff.histogram_obstacle <= req_chan.histogram_obstacle;
         frame_ff.left_count         <= req_chan.left_count;
         frame_ff.right_count        <= req_chan.right_count;
         frame_ff.now_ms             <= req_chan.now_ms;
      end
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_chan.valid        = result_valid_ff;
   assign rsp_chan.phase_out    = result_ff.phase_out;
   assign rsp_chan.obstacle_led = result_ff.obstacle_led;

   // A stalled result must never be overwritten by the phase logic.
   `OAP_ASSERT_SAME(a_no_overwrite, clock, reset,
      result_valid_ff && !rsp_chan.ready, !advance)
   // Every accepted frame lands in the input register.
   `OAP_ASSERT_NEXT(a_accept_loads, clock, reset, req_accept, frame_valid_ff)
   // Every frame that leaves the input register produces a result.
   `OAP_ASSERT_NEXT(a_advance_result, clock, reset, advance, result_valid_ff)
   // A frame that cannot move on stays in the input register.
   `OAP_ASSERT_NEXT(a_frame_holds, clock, reset,
      frame_valid_ff && !advance, frame_valid_ff)

endmodule

`default_nettype wire
